### sv/pfl_pkg.sv
// Shared widths, codes and controller/datapath handshake types of the slot free list.
package pfl_pkg;

    // Field widths of the stream words
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int WORD_W     = 32;
    localparam int PAY_W      = 5 * WORD_W;
    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = STATUS_W;

    // Default table size
    localparam int DEF_TABLE_DEPTH = 64;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_BAD_SLOT   = 2'd2,
        ST_MOVE_FULL  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
        logic scan;
        logic load_out;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_busy;
    } t_stat;

endpackage

### sv/pfl_ctrl.sv
// Request sequencer of the slot free list: accept, look up, execute, scan, deliver.
module pfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_vld,
    output logic          o_in_rdy,
    output pfl_pkg::t_cmd o_cmd,
    input  pfl_pkg::t_stat i_stat
);
    import pfl_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        o_in_rdy = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_rdy      = 1'b1;
                o_cmd.capture = i_in_vld;
                if (i_in_vld) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/pfl_dpath.sv
// Datapath of the slot free list: slot table, payload store, move list, counters, result register.
module pfl_dpath #(
    parameter int TABLE_DEPTH = pfl_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfl_pkg::t_cmd                      i_cmd,
    output pfl_pkg::t_stat                     o_stat,
    input  logic [pfl_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic [pfl_pkg::IN_USER_W-1:0]      i_in_user,
    output logic                               o_out_vld,
    input  logic                               i_out_rdy,
    output logic [pfl_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic [pfl_pkg::OUT_USER_W-1:0]     o_out_user
);
    import pfl_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
    localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(TABLE_DEPTH);

    // Memories: slot table holds {occupied, next link}, move list holds {valid, slot}
    logic [CNT_W:0]   r_slot_mem [TABLE_DEPTH];
    logic [PAY_W-1:0] r_pay_mem  [TABLE_DEPTH];
    logic [AW:0]      r_move_mem [TABLE_DEPTH];

    // Captured request
    logic              r_req;
    logic [SLOT_W-1:0] r_sid;
    logic [PAY_W-1:0]  r_pay;

    // Allocator state
    logic [CNT_W-1:0] r_head;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_mark;

    // Read data and scan pipeline
    logic [CNT_W:0]   r_slot_rd;
    logic [AW:0]      r_move_rd;
    logic [CNT_W-1:0] r_idx;
    logic [AW-1:0]    r_pidx;
    logic             r_pvld;

    // Staged result and output register
    logic [SLOT_W-1:0]     r_res_slot;
    t_status               r_res_status;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [CW-1:0]    sid_ext;
    logic             sid_bad;
    logic             head_null;
    logic             head_fresh;
    logic             fill_full;
    logic [CNT_W-1:0] head_link;
    logic             rm_occ;
    logic             ins_ok;
    logic             rm_ok;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             idx_in;
    logic             scan_hit;
    logic [SLOT_W-1:0] res_slot;
    t_status           res_status;

    // Decode the request against the current table state
    always_comb begin
        sid_ext    = CW'(r_sid);
        sid_bad    = sid_ext >= CW'(TABLE_DEPTH);
        head_null  = r_head == NULL_LINK;
        fill_full  = r_fill == FULL_FILL;
        // slots at or above the mark were never written and still link to their successor
        head_fresh = r_head >= r_mark;
        head_link  = head_fresh ? r_head + CNT_W'(1) : r_slot_rd[CNT_W-1:0];
        rm_occ     = (sid_ext < CW'(r_mark)) && r_slot_rd[CNT_W];
        ins_ok     = !head_null && !fill_full;
        rm_ok      = !sid_bad && rm_occ;
        rd_en      = (r_req == REQ_REMOVE) ? !sid_bad : !head_null;
        rd_addr    = (r_req == REQ_REMOVE) ? sid_ext[AW-1:0] : r_head[AW-1:0];
        idx_in     = r_idx < r_fill;
        scan_hit   = r_pvld && r_move_rd[AW] && (r_move_rd[AW-1:0] == sid_ext[AW-1:0]);
    end

    // Pick the result code and slot
    always_comb begin
        if (r_req == REQ_REMOVE) begin
            res_slot   = r_sid;
            res_status = rm_ok ? ST_OK : ST_BAD_SLOT;
        end else if (head_null) begin
            res_slot   = '0;
            res_status = ST_TABLE_FULL;
        end else if (fill_full) begin
            res_slot   = '0;
            res_status = ST_MOVE_FULL;
        end else begin
            res_slot   = SLOT_W'(r_head);
            res_status = ST_OK;
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_user[0];
            r_sid <= i_in_data[SLOT_W-1:0];
            r_pay <= i_in_data[SLOT_W +: PAY_W];
        end
    end

    // Slot table: read on lookup, write on execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup && rd_en) begin
            r_slot_rd <= r_slot_mem[rd_addr];
        end
        if (i_cmd.exec) begin
            if (r_req == REQ_INSERT && ins_ok) begin
                r_slot_mem[r_head[AW-1:0]] <= {1'b1, NULL_LINK};
            end else if (r_req == REQ_REMOVE && rm_ok) begin
                r_slot_mem[sid_ext[AW-1:0]] <= {1'b0, r_head};
            end
        end
    end

    // Payload store: box words and tag kept as opaque data
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_req == REQ_INSERT && ins_ok) begin
            r_pay_mem[r_head[AW-1:0]] <= r_pay;
        end
    end

    // Move list: append on insert, invalidate the first match during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && idx_in) begin
            r_move_rd <= r_move_mem[r_idx[AW-1:0]];
        end
        if (i_cmd.exec && r_req == REQ_INSERT && ins_ok) begin
            r_move_mem[r_fill[AW-1:0]] <= {1'b1, r_head[AW-1:0]};
        end else if (i_cmd.scan && scan_hit) begin
            r_move_mem[r_pidx] <= {1'b0, sid_ext[AW-1:0]};
        end
    end

    // Free head, counters and fresh-slot mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_live <= '0;
            r_fill <= '0;
            r_mark <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == REQ_INSERT && ins_ok) begin
                r_head <= head_link;
                r_live <= r_live + CNT_W'(1);
                r_fill <= r_fill + CNT_W'(1);
                if (head_fresh) begin
                    r_mark <= r_head + CNT_W'(1);
                end
            end else if (r_req == REQ_REMOVE && rm_ok) begin
                r_head <= CNT_W'(sid_ext);
                if (r_live != '0) begin
                    r_live <= r_live - CNT_W'(1);
                end
            end
        end
    end

    // Scan pointer: issue one read a cycle, compare the word read last cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pvld <= 1'b0;
        end else if (i_cmd.exec) begin
            r_idx  <= '0;
            r_pvld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pvld <= idx_in && !scan_hit;
            if (idx_in) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_pidx <= r_idx[AW-1:0];
        end
    end

    // Stage the result on execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_slot   <= res_slot;
            r_res_status <= res_status;
        end
    end

    // Output register: hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= OUT_DATA_W'({COUNT_W'(r_fill), COUNT_W'(r_live), r_res_slot});
            r_out_user <= r_res_status;
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

    // Status to the controller
    always_comb begin
        o_stat.need_scan = (r_req == REQ_REMOVE) && rm_ok;
        o_stat.scan_done = scan_hit || (!r_pvld && !idx_in);
        o_stat.out_busy  = r_out_vld && !i_out_rdy;
    end

endmodule

### sv/proxy_slot_free_list.sv
// Top level of the slot free list: stream ports, controller and datapath.
//
// Slot allocator over TABLE_DEPTH slots chained in a linked free list. An insert
// word takes the head slot, stores its box words and tag, appends the slot to the
// move list and answers with the slot; a remove word frees the slot and clears the
// first move-list entry that holds it. Every word gives one result word carrying
// the slot, a status code, the live count and the move-list fill. An insert, and a
// refused remove, passes through the look-up, execute and done states; a remove
// that frees a slot also scans the move list, one entry per cycle through its
// memory read port, up to the first match or the end of the filled list.
// Errors (table full, bad or free slot, move list full) change no state. The result
// sits in an output register, so the next word is taken while a result still waits
// for the sink. No clearing pass follows reset: slots never yet handed out are
// tracked by a mark and read as fresh.
module proxy_slot_free_list #(
    parameter int TABLE_DEPTH = pfl_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // slot_id[5:0], box_min_x[37:6], box_min_y[69:38], box_max_x[101:70],
    // box_max_y[133:102], user_tag[165:134], zero fill[167:166]
    input  logic [pfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic [pfl_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // assigned_slot[5:0], live_count[12:6], moved_count[19:13], zero fill[23:20]
    output logic [pfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [pfl_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import pfl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence each request
    pfl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_vld (s_axis_tvalid),
        .o_in_rdy (s_axis_tready),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    // Table, move list and result register
    pfl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .o_out_vld  (m_axis_tvalid),
        .i_out_rdy  (m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_out_user (m_axis_tuser)
    );

endmodule
